### rtl/atps_pkg.sv
// Shared types, constants and the reciprocal table of the adaptive temporal pixel smoother.
package atps_pkg;

  localparam int unsigned HISTORY_DEPTH = 7;
  localparam int unsigned MAX_PIXELS    = 65536;

  localparam int unsigned ADDR_W        = $clog2(MAX_PIXELS);
  localparam int unsigned SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int unsigned CENTRE_OFFSET = HISTORY_DEPTH - HISTORY_DEPTH / 2;

  localparam int unsigned RGB_W         = 24;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned STRENGTH_W    = 4;

  localparam int unsigned FULL_WEIGHT   = 16;
  localparam int unsigned WEIGHT_W      = $clog2(FULL_WEIGHT + 1);
  localparam int unsigned DIST_W        = 2 * CHAN_W + 2;
  localparam int unsigned TOTAL_W       = $clog2(FULL_WEIGHT * HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W         = CHAN_W + TOTAL_W;
  localparam int unsigned SCALE_W       = 13;
  localparam int unsigned PROD_W        = SUM_W + SCALE_W;
  localparam int unsigned UNITY_SHIFT   = 16;

  typedef logic [RGB_W-1:0]      rgb_t;
  typedef rgb_t [HISTORY_DEPTH-1:0] row_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [WEIGHT_W-1:0]   weight_t;

  // floor(65536 / total) for the totals that can occur (centre always weighs 16).
  function automatic logic [SCALE_W-1:0] scale_lookup(input logic [7:0] total);
    logic [SCALE_W-1:0] s;
    s = '0;
    case (total)
      8'd16:  s = 13'd4096;  8'd17:  s = 13'd3855;  8'd18:  s = 13'd3640;
      8'd19:  s = 13'd3449;  8'd20:  s = 13'd3276;  8'd21:  s = 13'd3120;
      8'd22:  s = 13'd2978;  8'd23:  s = 13'd2849;  8'd24:  s = 13'd2730;
      8'd25:  s = 13'd2621;  8'd26:  s = 13'd2520;  8'd27:  s = 13'd2427;
      8'd28:  s = 13'd2340;  8'd29:  s = 13'd2259;  8'd30:  s = 13'd2184;
      8'd31:  s = 13'd2114;  8'd32:  s = 13'd2048;  8'd33:  s = 13'd1985;
      8'd34:  s = 13'd1927;  8'd35:  s = 13'd1872;  8'd36:  s = 13'd1820;
      8'd37:  s = 13'd1771;  8'd38:  s = 13'd1724;  8'd39:  s = 13'd1680;
      8'd40:  s = 13'd1638;  8'd41:  s = 13'd1598;  8'd42:  s = 13'd1560;
      8'd43:  s = 13'd1524;  8'd44:  s = 13'd1489;  8'd45:  s = 13'd1456;
      8'd46:  s = 13'd1424;  8'd47:  s = 13'd1394;  8'd48:  s = 13'd1365;
      8'd49:  s = 13'd1337;  8'd50:  s = 13'd1310;  8'd51:  s = 13'd1285;
      8'd52:  s = 13'd1260;  8'd53:  s = 13'd1236;  8'd54:  s = 13'd1213;
      8'd55:  s = 13'd1191;  8'd56:  s = 13'd1170;  8'd57:  s = 13'd1149;
      8'd58:  s = 13'd1129;  8'd59:  s = 13'd1110;  8'd60:  s = 13'd1092;
      8'd61:  s = 13'd1074;  8'd62:  s = 13'd1057;  8'd63:  s = 13'd1040;
      8'd64:  s = 13'd1024;  8'd65:  s = 13'd1008;  8'd66:  s = 13'd992;
      8'd67:  s = 13'd978;   8'd68:  s = 13'd963;   8'd69:  s = 13'd949;
      8'd70:  s = 13'd936;   8'd71:  s = 13'd923;   8'd72:  s = 13'd910;
      8'd73:  s = 13'd897;   8'd74:  s = 13'd885;   8'd75:  s = 13'd873;
      8'd76:  s = 13'd862;   8'd77:  s = 13'd851;   8'd78:  s = 13'd840;
      8'd79:  s = 13'd829;   8'd80:  s = 13'd819;   8'd81:  s = 13'd809;
      8'd82:  s = 13'd799;   8'd83:  s = 13'd789;   8'd84:  s = 13'd780;
      8'd85:  s = 13'd771;   8'd86:  s = 13'd762;   8'd87:  s = 13'd753;
      8'd88:  s = 13'd744;   8'd89:  s = 13'd736;   8'd90:  s = 13'd728;
      8'd91:  s = 13'd720;   8'd92:  s = 13'd712;   8'd93:  s = 13'd704;
      8'd94:  s = 13'd697;   8'd95:  s = 13'd689;   8'd96:  s = 13'd682;
      8'd97:  s = 13'd675;   8'd98:  s = 13'd668;   8'd99:  s = 13'd661;
      8'd100: s = 13'd655;   8'd101: s = 13'd648;   8'd102: s = 13'd642;
      8'd103: s = 13'd636;   8'd104: s = 13'd630;   8'd105: s = 13'd624;
      8'd106: s = 13'd618;   8'd107: s = 13'd612;   8'd108: s = 13'd606;
      8'd109: s = 13'd601;   8'd110: s = 13'd595;   8'd111: s = 13'd590;
      8'd112: s = 13'd585;   8'd113: s = 13'd579;   8'd114: s = 13'd574;
      8'd115: s = 13'd569;   8'd116: s = 13'd564;   8'd117: s = 13'd560;
      8'd118: s = 13'd555;   8'd119: s = 13'd550;   8'd120: s = 13'd546;
      8'd121: s = 13'd541;   8'd122: s = 13'd537;   8'd123: s = 13'd532;
      8'd124: s = 13'd528;   8'd125: s = 13'd524;   8'd126: s = 13'd520;
      8'd127: s = 13'd516;   8'd128: s = 13'd512;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

### rtl/adaptive_temporal_pixel_smoother_unit.sv
// Top level of the adaptive temporal pixel smoother: history memory and filter pipeline.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_ready_o    pixel_rgb_i, pixel_index_i, frame_end_i
//   out      source     out_valid_o / out_ready_i  smoothed_rgb_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_data_i (strength)
//
// One pixel transfer per clock while the output register is free or being read. The rate is
// set by the history memory: one wide row (all slots of a pixel) is read and written per cycle.
// Reset clears the slot pointer, the first-frame flag, strength and all stage valid bits; the
// history memory is not cleared. A stalled output freezes every stage at once, so nothing is
// dropped or repeated; bubbles travel through the stages like items.
module adaptive_temporal_pixel_smoother_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] pixel_rgb_i,
  input  logic [15:0] pixel_index_i,
  input  logic        frame_end_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] smoothed_rgb_o,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned D = atps_pkg::HISTORY_DEPTH;

  // ---------------------------------------------------------------------------
  // Global advance: the whole pipeline moves when the output register is free.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_q;
  logic in_xfer;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_xfer    = in_valid_i && adv;

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Control state: strength, first-frame flag, write slot.
  // ---------------------------------------------------------------------------
  logic [atps_pkg::STRENGTH_W-1:0] strength_q;
  logic                            first_q, first_d;
  logic [atps_pkg::SLOT_W-1:0]     ws_q, ws_d;

  always_comb begin
    first_d = first_q;
    ws_d    = ws_q;
    if (in_xfer && frame_end_i) begin
      if (first_q) begin
        first_d = 1'b0;
        ws_d    = atps_pkg::SLOT_W'(1 % D);
      end else if (ws_q == atps_pkg::SLOT_W'(D - 1)) begin
        ws_d = '0;
      end else begin
        ws_d = ws_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= '0;
      first_q    <= 1'b1;
      ws_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        strength_q <= cfg_data_i;
      end
      first_q <= first_d;
      ws_q    <= ws_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: transfer registered, history row read in the same edge.
  // ---------------------------------------------------------------------------
  logic                          v1_q;
  atps_pkg::rgb_t                pix1_q;
  logic [atps_pkg::ADDR_W-1:0]   addr1_q;
  logic                          first1_q;
  logic [atps_pkg::SLOT_W-1:0]   ws1_q;
  atps_pkg::row_t                rd_q;

  atps_pkg::row_t                hist_mem_q [atps_pkg::MAX_PIXELS];

  // most recent row write, to cover a read issued at the edge of that write
  logic                          fwd_v_q;
  logic [atps_pkg::ADDR_W-1:0]   fwd_addr_q;
  atps_pkg::row_t                fwd_row_q;

  atps_pkg::row_t                base_row;
  atps_pkg::row_t                merged_row;
  atps_pkg::rgb_t                centre;
  logic [atps_pkg::SLOT_W:0]     cs_sum;
  logic [atps_pkg::SLOT_W-1:0]   cs;

  always_comb begin
    base_row = (fwd_v_q && (fwd_addr_q == addr1_q)) ? fwd_row_q : rd_q;
    cs_sum   = {1'b0, ws1_q} + (atps_pkg::SLOT_W + 1)'(atps_pkg::CENTRE_OFFSET);
    if (cs_sum >= (atps_pkg::SLOT_W + 1)'(D)) begin
      cs_sum = cs_sum - (atps_pkg::SLOT_W + 1)'(D);
    end
    cs     = cs_sum[atps_pkg::SLOT_W-1:0];
    centre = base_row[cs];
    // first frame fills every slot; later frames replace only the write slot
    merged_row = base_row;
    for (int i = 0; i < D; i++) begin
      if (first1_q || (ws1_q == atps_pkg::SLOT_W'(i))) begin
        merged_row[i] = pix1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_q <= hist_mem_q[pixel_index_i[atps_pkg::ADDR_W-1:0]];
      if (v1_q) begin
        hist_mem_q[addr1_q] <= merged_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      fwd_v_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      if (v1_q) begin
        fwd_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix1_q   <= pixel_rgb_i;
      addr1_q  <= pixel_index_i[atps_pkg::ADDR_W-1:0];
      first1_q <= first_q;
      ws1_q    <= ws_q;
      if (v1_q) begin
        fwd_addr_q <= addr1_q;
        fwd_row_q  <= merged_row;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squared color distance of every slot to the centre.
  // ---------------------------------------------------------------------------
  logic           v2_q;
  logic           first2_q;
  atps_pkg::rgb_t pix2_q;
  atps_pkg::row_t row2_q;
  atps_pkg::rgb_t centre2_q;

  atps_pkg::dist_t sq_dist [D];

  always_comb begin
    for (int i = 0; i < D; i++) begin
      sq_dist[i] = '0;
      for (int c = 0; c < 3; c++) begin
        logic [atps_pkg::CHAN_W-1:0]   a, b, d;
        logic [2*atps_pkg::CHAN_W-1:0] sq;
        a  = row2_q[i][c*atps_pkg::CHAN_W +: atps_pkg::CHAN_W];
        b  = centre2_q[c*atps_pkg::CHAN_W +: atps_pkg::CHAN_W];
        d  = (a > b) ? (a - b) : (b - a);
        sq = (2*atps_pkg::CHAN_W)'(d) * (2*atps_pkg::CHAN_W)'(d);
        sq_dist[i] = sq_dist[i] + atps_pkg::DIST_W'(sq);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: shift by strength, clamp, turn into weights.
  // ---------------------------------------------------------------------------
  logic            v3_q;
  logic            first3_q;
  atps_pkg::rgb_t  pix3_q;
  atps_pkg::row_t  row3_q;
  atps_pkg::dist_t dist3_q [D];

  atps_pkg::weight_t wgt [D];

  always_comb begin
    for (int i = 0; i < D; i++) begin
      atps_pkg::dist_t sh;
      sh = dist3_q[i] >> strength_q;
      if (sh > atps_pkg::DIST_W'(atps_pkg::FULL_WEIGHT)) begin
        wgt[i] = '0;
      end else begin
        wgt[i] = atps_pkg::WEIGHT_W'(atps_pkg::FULL_WEIGHT) - sh[atps_pkg::WEIGHT_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: weighted channel sums and total weight.
  // ---------------------------------------------------------------------------
  logic              v4_q;
  logic              first4_q;
  atps_pkg::rgb_t    pix4_q;
  atps_pkg::row_t    row4_q;
  atps_pkg::weight_t wgt4_q [D];

  logic [atps_pkg::SUM_W-1:0]   sum [3];
  logic [atps_pkg::TOTAL_W-1:0] total;

  always_comb begin
    total = '0;
    for (int c = 0; c < 3; c++) begin
      sum[c] = '0;
    end
    for (int i = 0; i < D; i++) begin
      total = total + atps_pkg::TOTAL_W'(wgt4_q[i]);
      for (int c = 0; c < 3; c++) begin
        sum[c] = sum[c] +
                 atps_pkg::SUM_W'(row4_q[i][c*atps_pkg::CHAN_W +: atps_pkg::CHAN_W]) *
                 atps_pkg::SUM_W'(wgt4_q[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: reciprocal of the total weight from the table.
  // ---------------------------------------------------------------------------
  logic                         v5_q;
  logic                         first5_q;
  atps_pkg::rgb_t               pix5_q;
  logic [atps_pkg::SUM_W-1:0]   sum5_q [3];
  logic [atps_pkg::TOTAL_W-1:0] total5_q;

  // ---------------------------------------------------------------------------
  // Stage 6: scale each sum and drop the fraction.
  // ---------------------------------------------------------------------------
  logic                         v6_q;
  logic                         first6_q;
  atps_pkg::rgb_t               pix6_q;
  logic [atps_pkg::SUM_W-1:0]   sum6_q [3];
  logic [atps_pkg::SCALE_W-1:0] scale6_q;

  atps_pkg::rgb_t filtered;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [atps_pkg::PROD_W-1:0] prod;
      prod = atps_pkg::PROD_W'(sum6_q[c]) * atps_pkg::PROD_W'(scale6_q);
      filtered[c*atps_pkg::CHAN_W +: atps_pkg::CHAN_W] =
        prod[atps_pkg::UNITY_SHIFT +: atps_pkg::CHAN_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage registers 2..6 and the output register.
  // ---------------------------------------------------------------------------
  atps_pkg::rgb_t smoothed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      first2_q  <= first1_q;
      pix2_q    <= pix1_q;
      row2_q    <= merged_row;
      centre2_q <= centre;

      first3_q  <= first2_q;
      pix3_q    <= pix2_q;
      row3_q    <= row2_q;
      dist3_q   <= sq_dist;

      first4_q  <= first3_q;
      pix4_q    <= pix3_q;
      row4_q    <= row3_q;
      wgt4_q    <= wgt;

      first5_q  <= first4_q;
      pix5_q    <= pix4_q;
      sum5_q    <= sum;
      total5_q  <= total;

      first6_q  <= first5_q;
      pix6_q    <= pix5_q;
      sum6_q    <= sum5_q;
      scale6_q  <= atps_pkg::scale_lookup(8'(total5_q));

      // first frame passes the pixel through unchanged
      smoothed_q <= first6_q ? pix6_q : filtered;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign smoothed_rgb_o = smoothed_q;

endmodule
